// File: rtl/arpc_pkg.sv
// Package for the ARP cache resolver: action, status and send codes,
// sequencer states and the slot record. No dependencies.
`default_nettype none

package arpc_pkg;

    typedef enum logic [1:0] {
        ACT_RESOLVE = 2'd0,
        ACT_RECEIVE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISS      = 2'd1,
        ST_TOO_SHORT = 2'd2,
        ST_BAD_TYPE  = 2'd3
    } t_status;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BCAST = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    localparam logic [1:0] CFG_OWN_MAC = 2'd0;
    localparam logic [1:0] CFG_OWN_IP  = 2'd1;
    localparam logic [1:0] CFG_TTL_MS  = 2'd2;

    localparam logic [15:0] MIN_FRAME_LEN = 16'd42;
    localparam logic [15:0] HW_ETHERNET   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4    = 16'h0800;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [31:0] TTL_RESET     = 32'd300000;
    localparam logic [47:0] MAC_BCAST     = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } t_slot;

endpackage

`default_nettype wire

// File: rtl/arpc_slot_ram.sv
// Slot store of the ARP cache: one write port, one registered read port.
// Depends on arpc_pkg (t_slot).
`default_nettype none

module arpc_slot_ram #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [IW-1:0]        i_waddr,
    input  arpc_pkg::t_slot     i_wdata,
    input  wire [IW-1:0]        i_raddr,
    output arpc_pkg::t_slot     o_rdata
);

    arpc_pkg::t_slot r_mem [ENTRIES];
    arpc_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/arp_cache_resolver.sv
// ARP cache resolver top level: sequencer, valid bits, result register.
// Depends on arpc_pkg and arpc_slot_ram.
`default_nettype none
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one action per transfer:
//   resolve, receive a parsed ARP header, or clear. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result per action.
//   Config port (i_cfg_we, i_cfg_index, i_cfg_data) writes own_mac, own_ip,
//   ttl_ms; write only while the block is idle. own_mac is accepted but not
//   stored since no result depends on it.
// Sequencing
//   The slot store has a registered read, so each slot visit passes through
//   a read state and a check state (S_RD, S_CHK). Resolve visits slots up
//   to the hit, at most ENTRIES. Receive with insert visits slots up to the
//   match, at most ENTRIES, then passes through the write state (S_WR).
//   Clear, bad frames and the unused action go straight to the final state.
//   One action is in flight at a time; a new one is taken while the last
//   result still waits in the output register.
// Reset
//   Synchronous active low. Valid bits clear at once so every slot reads
//   empty; no clearing pass. Clear likewise drops all valid bits at once.
// Stall
//   A stalled result holds in the output register; the sequencer waits in
//   its final state until the register frees up.
//
module arp_cache_resolver #(
    parameter int ENTRIES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_index,
    input  wire [47:0]  i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [1:0]   i_action,
    input  wire [31:0]  i_now_ms,
    input  wire [31:0]  i_target_ip,
    input  wire [31:0]  i_sender_ip,
    input  wire [47:0]  i_sender_mac,
    input  wire [15:0]  i_hw_type,
    input  wire [15:0]  i_proto_type,
    input  wire [15:0]  i_opcode,
    input  wire [15:0]  i_frame_len,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic [47:0] o_found_mac,
    output logic [1:0]  o_send_kind,
    output logic [47:0] o_send_dest_mac,
    output logic [31:0] o_send_target_ip
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    arpc_pkg::t_state r_state, n_state;

    logic [31:0] r_own_ip, r_ttl_ms;

    // latched item
    logic        r_resolve;
    logic [31:0] r_now, r_target, r_sip;
    logic [47:0] r_smac;
    logic        r_reply;

    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_widx;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;

    // pending result
    logic [1:0]  r_res_status, r_res_kind;
    logic [47:0] r_res_found, r_res_dest;
    logic [31:0] r_res_tip;

    arpc_pkg::t_slot rd_slot, wr_slot;
    logic            mem_we;

    logic        accept, out_free, last;
    logic        slot_v, expired, ip_hit, ins_match;
    logic [31:0] age, stamp_in;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;
    assign last     = (r_idx == LAST);

    assign slot_v    = r_valid[r_idx];
    assign age       = r_now - rd_slot.stamp;
    assign expired   = slot_v && (age > r_ttl_ms);
    assign ip_hit    = slot_v && !expired && (rd_slot.ip == r_target);
    assign ins_match = slot_v && (rd_slot.ip == r_sip);
    assign stamp_in  = (r_now == 32'd0) ? 32'd1 : r_now;

    assign wr_slot.ip    = r_sip;
    assign wr_slot.mac   = r_smac;
    assign wr_slot.stamp = stamp_in;

    arpc_slot_ram #(.ENTRIES(ENTRIES), .IW(IW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_widx),
        .i_wdata (wr_slot),
        .i_raddr (r_idx),
        .o_rdata (rd_slot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arpc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == arpc_pkg::ACT_RESOLVE) begin
                        n_state = arpc_pkg::S_RD;
                    end else if (i_action == arpc_pkg::ACT_RECEIVE
                                 && i_frame_len >= arpc_pkg::MIN_FRAME_LEN
                                 && i_hw_type == arpc_pkg::HW_ETHERNET
                                 && i_proto_type == arpc_pkg::PROTO_IPV4) begin
                        n_state = arpc_pkg::S_RD;
                    end else begin
                        n_state = arpc_pkg::S_DONE;
                    end
                end
            end
            arpc_pkg::S_RD: n_state = arpc_pkg::S_CHK;
            arpc_pkg::S_CHK: begin
                if (r_resolve) begin
                    n_state = (ip_hit || last) ? arpc_pkg::S_DONE : arpc_pkg::S_RD;
                end else begin
                    n_state = (ins_match || last) ? arpc_pkg::S_WR : arpc_pkg::S_RD;
                end
            end
            arpc_pkg::S_WR: n_state = arpc_pkg::S_DONE;
            arpc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = arpc_pkg::S_IDLE;
                end
            end
            default: n_state = arpc_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = (r_state != arpc_pkg::S_IDLE);
        mem_we     = (r_state == arpc_pkg::S_WR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arpc_pkg::S_IDLE;
            r_own_ip    <= '0;
            r_ttl_ms    <= arpc_pkg::TTL_RESET;
            r_valid     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_index == arpc_pkg::CFG_OWN_IP) begin
                    r_own_ip <= i_cfg_data[31:0];
                end else if (i_cfg_index == arpc_pkg::CFG_TTL_MS) begin
                    r_ttl_ms <= i_cfg_data[31:0];
                end
            end

            if (accept && i_action == arpc_pkg::ACT_CLEAR) begin
                r_valid <= '0;
            end else if (r_state == arpc_pkg::S_CHK && r_resolve && expired) begin
                r_valid[r_idx] <= 1'b0;
            end else if (mem_we) begin
                r_valid[r_widx] <= 1'b1;
            end

            // load a new result, else drop the one just taken
            if (r_state == arpc_pkg::S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_resolve    <= (i_action == arpc_pkg::ACT_RESOLVE);
            r_now        <= i_now_ms;
            r_target     <= i_target_ip;
            r_sip        <= i_sender_ip;
            r_smac       <= i_sender_mac;
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_reply      <= (i_opcode == arpc_pkg::OP_REQUEST) && (i_target_ip == r_own_ip);
            r_res_found  <= '0;
            r_res_kind   <= arpc_pkg::KIND_NONE;
            r_res_dest   <= '0;
            r_res_tip    <= '0;
            if (i_action == arpc_pkg::ACT_RECEIVE
                && i_frame_len < arpc_pkg::MIN_FRAME_LEN) begin
                r_res_status <= arpc_pkg::ST_TOO_SHORT;
            end else if (i_action == arpc_pkg::ACT_RECEIVE
                         && (i_hw_type != arpc_pkg::HW_ETHERNET
                             || i_proto_type != arpc_pkg::PROTO_IPV4)) begin
                r_res_status <= arpc_pkg::ST_BAD_TYPE;
            end else begin
                r_res_status <= arpc_pkg::ST_OK;
            end
        end else if (r_state == arpc_pkg::S_CHK) begin
            r_idx <= r_idx + 1'b1;
            if (r_resolve) begin
                if (ip_hit) begin
                    r_res_found <= rd_slot.mac;
                end else if (last) begin
                    r_res_status <= arpc_pkg::ST_MISS;
                    r_res_kind   <= arpc_pkg::KIND_BCAST;
                    r_res_dest   <= arpc_pkg::MAC_BCAST;
                    r_res_tip    <= r_target;
                end
            end else begin
                // track first empty slot on the way
                if (!slot_v && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_idx;
                end
                if (ins_match) begin
                    r_widx <= r_idx;
                end else if (!slot_v && !r_free_found) begin
                    r_widx <= r_idx;
                end else begin
                    r_widx <= r_free_found ? r_free_idx : '0;
                end
                if (r_reply) begin
                    r_res_kind <= arpc_pkg::KIND_REPLY;
                    r_res_dest <= r_smac;
                    r_res_tip  <= r_sip;
                end
            end
        end

        if (r_state == arpc_pkg::S_DONE && out_free) begin
            o_status         <= r_res_status;
            o_found_mac      <= r_res_found;
            o_send_kind      <= r_res_kind;
            o_send_dest_mac  <= r_res_dest;
            o_send_target_ip <= r_res_tip;
        end
    end

endmodule

`default_nettype wire

// File: rtl/arpc_checker.sv
// Port-level checker for the ARP cache resolver, bound to the top level.
// Depends on arpc_pkg and arp_cache_resolver.
`default_nettype none

module arpc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [1:0]  o_status,
    input wire [47:0] o_found_mac,
    input wire [1:0]  o_send_kind,
    input wire [47:0] o_send_dest_mac
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_found_mac))
        else $error("stalled result changed");

    a_bcast_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_kind == arpc_pkg::KIND_BCAST |->
            o_status == arpc_pkg::ST_MISS && o_send_dest_mac == arpc_pkg::MAC_BCAST)
        else $error("broadcast without resolve miss");

    a_bad_frame_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == arpc_pkg::ST_TOO_SHORT
            || o_status == arpc_pkg::ST_BAD_TYPE) |->
            o_send_kind == arpc_pkg::KIND_NONE && o_found_mac == 48'd0)
        else $error("rejected frame produced output");

endmodule

bind arp_cache_resolver arpc_checker u_arpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_found_mac     (o_found_mac),
    .o_send_kind     (o_send_kind),
    .o_send_dest_mac (o_send_dest_mac)
);

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for arp_cache_resolver: directed and random traffic,
// with an in-bench cache predictor. Depends on arpc_pkg and the block's RTL.
`default_nettype none

module tb;

    localparam int SLOTS = 16;

    typedef struct {
        arpc_pkg::t_action action;
        logic [31:0] now_ms;
        logic [31:0] target_ip;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] opcode;
        logic [15:0] frame_len;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic [47:0] found_mac;
        logic [1:0]  send_kind;
        logic [47:0] dest_mac;
        logic [31:0] target_ip;
    } t_rsp;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = arpc_pkg::CFG_OWN_MAC;
    logic [47:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = arpc_pkg::ACT_NONE;
    logic [31:0] now_ms = '0, target_ip = '0, sender_ip = '0;
    logic [47:0] sender_mac = '0;
    logic [15:0] hw_type = '0, proto_type = '0, opcode = '0, frame_len = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status, send_kind;
    logic [47:0] found_mac, dest_mac;
    logic [31:0] send_tip;

    arp_cache_resolver #(.ENTRIES(SLOTS)) i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(action), .i_now_ms(now_ms), .i_target_ip(target_ip),
        .i_sender_ip(sender_ip), .i_sender_mac(sender_mac), .i_hw_type(hw_type),
        .i_proto_type(proto_type), .i_opcode(opcode), .i_frame_len(frame_len),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_found_mac(found_mac), .o_send_kind(send_kind),
        .o_send_dest_mac(dest_mac), .o_send_target_ip(send_tip)
    );

    always #5 clk = ~clk;

    // predictor copy of the cache and registers
    logic [31:0] m_ip [SLOTS];
    logic [47:0] m_mac [SLOTS];
    logic [31:0] m_stamp [SLOTS];
    logic [31:0] m_own_ip = '0;
    logic [31:0] m_ttl = arpc_pkg::TTL_RESET;

    // settings for the next phase, written by the stimulus thread
    logic [31:0] cfg_own_ip = '0;
    logic [31:0] cfg_ttl = arpc_pkg::TTL_RESET;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   n_results = 0;
    int   n_hits = 0;
    int   n_replies = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;

    // recent addresses, so lookups and refreshes actually hit
    logic [31:0] ip_pool[$];

    function automatic int m_ttl_hint();
        return (cfg_ttl > 32'd4000000) ? 4000000 : int'(cfg_ttl);
    endfunction

    function automatic t_rsp cache_step(t_req r);
        t_rsp res = '{default: '0};
        logic [31:0] stamp;
        bit hit = 0, done = 0;
        case (r.action)
            arpc_pkg::ACT_RESOLVE: begin
                for (int i = 0; i < SLOTS && !hit; i++) begin
                    if (m_stamp[i] != 0) begin
                        if (r.now_ms - m_stamp[i] > m_ttl) begin
                            m_stamp[i] = '0;
                        end else if (m_ip[i] == r.target_ip) begin
                            res.found_mac = m_mac[i];
                            hit = 1;
                        end
                    end
                end
                if (!hit) begin
                    res.status = arpc_pkg::ST_MISS;
                    res.send_kind = arpc_pkg::KIND_BCAST;
                    res.dest_mac = arpc_pkg::MAC_BCAST;
                    res.target_ip = r.target_ip;
                end
            end
            arpc_pkg::ACT_RECEIVE: begin
                if (r.frame_len < arpc_pkg::MIN_FRAME_LEN) begin
                    res.status = arpc_pkg::ST_TOO_SHORT;
                end else if (r.hw_type != arpc_pkg::HW_ETHERNET
                             || r.proto_type != arpc_pkg::PROTO_IPV4) begin
                    res.status = arpc_pkg::ST_BAD_TYPE;
                end else begin
                    stamp = (r.now_ms == 0) ? 32'd1 : r.now_ms;
                    for (int i = 0; i < SLOTS && !done; i++) begin
                        if (m_stamp[i] != 0 && m_ip[i] == r.sender_ip) begin
                            m_mac[i] = r.sender_mac;
                            m_stamp[i] = stamp;
                            done = 1;
                        end
                    end
                    for (int i = 0; i < SLOTS && !done; i++) begin
                        if (m_stamp[i] == 0) begin
                            m_ip[i] = r.sender_ip;
                            m_mac[i] = r.sender_mac;
                            m_stamp[i] = stamp;
                            done = 1;
                        end
                    end
                    if (!done) begin
                        m_ip[0] = r.sender_ip;
                        m_mac[0] = r.sender_mac;
                        m_stamp[0] = stamp;
                    end
                    if (r.opcode == arpc_pkg::OP_REQUEST && r.target_ip == m_own_ip) begin
                        res.send_kind = arpc_pkg::KIND_REPLY;
                        res.dest_mac = r.sender_mac;
                        res.target_ip = r.sender_ip;
                    end
                end
            end
            arpc_pkg::ACT_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    m_ip[i] = '0;
                    m_mac[i] = '0;
                    m_stamp[i] = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Driver: present the next item; hold it while stalled.
    always @(posedge clk) begin
        t_req r;
        if (rst_n) begin
            if (!in_valid || !in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = pending_reqs.pop_front();
                    expected_rsps.push_back(cache_step(r));
                    in_valid <= 1'b1;
                    action <= r.action;
                    now_ms <= r.now_ms;
                    target_ip <= r.target_ip;
                    sender_ip <= r.sender_ip;
                    sender_mac <= r.sender_mac;
                    hw_type <= r.hw_type;
                    proto_type <= r.proto_type;
                    opcode <= r.opcode;
                    frame_len <= r.frame_len;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: every result transfer is checked against the oldest expectation.
    always @(posedge clk) begin
        t_rsp e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_rsps.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_rsps.pop_front();
                n_results++;
                if (e.status == arpc_pkg::ST_OK && e.found_mac != 0) n_hits++;
                if (e.send_kind == arpc_pkg::KIND_REPLY) n_replies++;
                if (status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, status);
                    errors++;
                end
                if (found_mac !== e.found_mac) begin
                    $error("found_mac exp %h got %h", e.found_mac, found_mac);
                    errors++;
                end
                if (send_kind !== e.send_kind) begin
                    $error("send_kind exp %0d got %0d", e.send_kind, send_kind);
                    errors++;
                end
                if (dest_mac !== e.dest_mac) begin
                    $error("send_dest_mac exp %h got %h", e.dest_mac, dest_mac);
                    errors++;
                end
                if (send_tip !== e.target_ip) begin
                    $error("send_target_ip exp %h got %h", e.target_ip, send_tip);
                    errors++;
                end
            end
        end
    end

    function automatic t_req make_req(arpc_pkg::t_action a, logic [31:0] now_v,
                                      logic [31:0] tgt);
        t_req r;
        r.action = a;
        r.now_ms = now_v;
        r.target_ip = tgt;
        r.sender_ip = $urandom;
        r.sender_mac = 48'({$urandom, $urandom});
        r.hw_type = arpc_pkg::HW_ETHERNET;
        r.proto_type = arpc_pkg::PROTO_IPV4;
        r.opcode = arpc_pkg::OP_REQUEST;
        r.frame_len = arpc_pkg::MIN_FRAME_LEN;
        return r;
    endfunction

    function automatic logic [31:0] pick_ip();
        if (ip_pool.size() > 0 && $urandom_range(3) != 0)
            return ip_pool[$urandom_range(ip_pool.size() - 1)];
        return $urandom;
    endfunction

    // Random traffic around a slowly advancing clock, mostly well-formed frames.
    task automatic add_random(int count, logic [31:0] base_ms);
        t_req r;
        logic [31:0] t = base_ms;
        int pick;
        for (int n = 0; n < count; n++) begin
            t = t + $urandom_range(m_ttl_hint() / 8 + 1);
            if ($urandom_range(19) == 0) t = $urandom;
            r = make_req(arpc_pkg::ACT_RESOLVE, t, pick_ip());
            pick = $urandom_range(99);
            if (pick < 40) begin
                r.action = arpc_pkg::ACT_RESOLVE;
            end else if (pick < 90) begin
                r.action = arpc_pkg::ACT_RECEIVE;
                r.sender_ip = pick_ip();
                r.target_ip = ($urandom_range(2) == 0) ? cfg_own_ip : $urandom;
                r.opcode = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
                r.frame_len = ($urandom_range(9) == 0) ? 16'($urandom_range(41))
                                                        : 16'($urandom);
                if ($urandom_range(9) == 0) r.frame_len = 16'($urandom_range(42, 65535));
                if ($urandom_range(14) == 0) r.hw_type = 16'($urandom);
                if ($urandom_range(14) == 0) r.proto_type = 16'($urandom);
                if (r.frame_len < arpc_pkg::MIN_FRAME_LEN && $urandom_range(1))
                    r.frame_len = 16'd60;
            end else if (pick < 93) begin
                r.action = arpc_pkg::ACT_CLEAR;
            end else begin
                r.action = arpc_pkg::ACT_NONE;
            end
            if (ip_pool.size() < 24) ip_pool.push_back(r.sender_ip);
            else ip_pool[$urandom_range(23)] = r.sender_ip;
            pending_reqs.push_back(r);
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid)
            @(posedge clk);
        repeat (2 * SLOTS + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == arpc_pkg::CFG_OWN_IP) m_own_ip = val[31:0];
        if (idx == arpc_pkg::CFG_TTL_MS) m_ttl = val[31:0];
    endtask

    initial begin
        t_req r;
        for (int i = 0; i < SLOTS; i++) begin
            m_ip[i] = '0;
            m_mac[i] = '0;
            m_stamp[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty miss, zero stamp, bad frames, fill past capacity, expiry
        cfg_own_ip = 32'hC0A8_0001;
        write_reg(arpc_pkg::CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        write_reg(arpc_pkg::CFG_OWN_IP, {16'h0, cfg_own_ip});
        write_reg(arpc_pkg::CFG_TTL_MS, 48'd1000);
        cfg_ttl = 32'd1000;
        pending_reqs.push_back(make_req(arpc_pkg::ACT_RESOLVE, 32'd0, 32'hFFFF_FFFF));
        r = make_req(arpc_pkg::ACT_RECEIVE, 32'd0, cfg_own_ip);
        r.sender_ip = 32'h0;
        r.sender_mac = 48'hFFFF_FFFF_FFFF;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(arpc_pkg::ACT_RESOLVE, 32'd1001, 32'h0));
        pending_reqs.push_back(make_req(arpc_pkg::ACT_RESOLVE, 32'd1002, 32'h0));
        r = make_req(arpc_pkg::ACT_RECEIVE, 32'd5, 32'h0);
        r.frame_len = 16'd41;
        pending_reqs.push_back(r);
        r.frame_len = 16'hFFFF;
        r.hw_type = 16'hFFFF;
        pending_reqs.push_back(r);
        r.hw_type = arpc_pkg::HW_ETHERNET;
        r.proto_type = 16'h0000;
        pending_reqs.push_back(r);
        for (int i = 0; i < SLOTS + 2; i++) begin
            r = make_req(arpc_pkg::ACT_RECEIVE, 32'd10 + i, (i == 3) ? cfg_own_ip : 32'h1);
            r.sender_ip = 32'h0A00_0000 + i;
            r.opcode = (i == 5) ? 16'd2 : arpc_pkg::OP_REQUEST;
            pending_reqs.push_back(r);
        end
        pending_reqs.push_back(make_req(arpc_pkg::ACT_RESOLVE, 32'd20, 32'h0A00_0010));
        pending_reqs.push_back(make_req(arpc_pkg::ACT_RESOLVE, 32'hFFFF_FFFF, 32'h0A00_0005));
        pending_reqs.push_back(make_req(arpc_pkg::ACT_NONE, 32'd30, 32'h0A00_0005));
        pending_reqs.push_back(make_req(arpc_pkg::ACT_CLEAR, 32'd30, 32'h0));
        pending_reqs.push_back(make_req(arpc_pkg::ACT_RESOLVE, 32'd31, 32'h0A00_0007));
        wait_idle();

        // random phases: each idling mix, several register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            case (ph)
                0: cfg_ttl = arpc_pkg::TTL_RESET;
                1: cfg_ttl = 32'd0;
                2: cfg_ttl = 32'hFFFF_FFFF;
                3: cfg_ttl = 32'd50;
                default: cfg_ttl = $urandom_range(100000);
            endcase
            cfg_own_ip = (ph == 5) ? 32'hFFFF_FFFF : (ph == 6) ? 32'h0 : $urandom;
            write_reg(arpc_pkg::CFG_OWN_MAC, 48'({$urandom, $urandom}));
            write_reg(arpc_pkg::CFG_OWN_IP, {16'h0, cfg_own_ip});
            write_reg(arpc_pkg::CFG_TTL_MS, {16'h0, cfg_ttl});
            add_random(200, $urandom);
            wait_idle();
        end
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge clk);

        $display("tb: %0d results checked, %0d lookup hits, %0d replies requested",
                 n_results, n_hits, n_replies);
        $display("tb: phases covered idle and stall mixes, ttl 0 to max, own_ip extremes");
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
